>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, all clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define SACF_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define SACF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sacf_pkg.sv
// ----------------------------------------------------------------------------
// sacf_pkg
// Geometry, request codes and beat types of the cache tag array.
// ----------------------------------------------------------------------------
package sacf_pkg;

    localparam int SETS       = 8;
    localparam int WAYS       = 4;
    localparam int LINE_BYTES = 32;
    localparam int ADDR_W     = 64;

    localparam int LINE_SHIFT = $clog2(LINE_BYTES);
    localparam int LN_W       = ADDR_W - LINE_SHIFT;
    localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_MAINT = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] addr;
        logic              clean_flag;
        logic              inval_flag;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic              writeback_valid;
        logic [ADDR_W-1:0] writeback_addr;
        logic              fill_valid;
        logic [ADDR_W-1:0] fill_addr;
    } rsp_t;

    // One way of a tag row; the valid mark lives in flops outside the RAM.
    typedef struct packed {
        logic            dirty;
        logic [LN_W-1:0] ln;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

endpackage

>>> rtl/sacf_ram.sv
// ----------------------------------------------------------------------------
// sacf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/set_assoc_cache_fifo_tags.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_tags
// Tag array of a write-back, write-allocate set-associative cache with
// per-set FIFO replacement and single-line clean / invalidate maintenance.
// ----------------------------------------------------------------------------
//
//   channel   handshake           payload   beat taken when
//   -------   -----------------   -------   -----------------------------
//   request   start / busy        req       start && !busy at clk rise
//   result    done (strobe)       rsp       done high, one cycle, no stall
//
// The accept edge launches the read of the set's tag row from the tag RAM;
// the following cycle (busy high) compares all ways, writes the updated row
// back and registers the result, which shows on rsp with done in the next
// cycle, while a new request may already be taken. Busy holds off any new
// request during the lookup, as the tag RAM read is registered ahead of the
// read-modify-write.
// Reset clears the valid marks and FIFO pointers in flops; the RAM contents
// need no clearing. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_tags
    import sacf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic state_reg, state_next;
    logic accept;

    // Request held for the lookup cycle.
    req_t req_reg;

    // Valid marks and FIFO pointers in flops: both clear on reset.
    logic [SETS-1:0][WAYS-1:0]  valid_reg, valid_next;
    logic [SETS-1:0][WAY_W-1:0] oldest_reg, oldest_next;

    logic done_reg, done_next;
    rsp_t rsp_reg, rsp_next;

    // Tag RAM ports.
    logic [SET_W-1:0] rd_set;
    logic [ROW_W-1:0] rd_data;
    row_t             row;
    row_t             row_new;

    // Lookup decode.
    logic [LN_W-1:0]  ln;
    logic [SET_W-1:0] set_idx;
    logic             is_access;
    logic             is_store;
    logic             is_maint;
    logic             hit_found;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim;

    assign accept = start && !busy;
    assign busy   = (state_reg == ST_LOOK);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    // Set index of the incoming request, used to launch the row read.
    assign rd_set = (SETS > 1) ? req.addr[LINE_SHIFT +: SET_W] : '0;

    assign ln        = req_reg.addr[ADDR_W-1:LINE_SHIFT];
    assign set_idx   = (SETS > 1) ? ln[SET_W-1:0] : '0;
    assign is_access = (req_reg.func == FUNC_READ) || (req_reg.func == FUNC_WRITE);
    assign is_store  = (req_reg.func == FUNC_WRITE);
    assign is_maint  = (req_reg.func == FUNC_MAINT);
    assign victim    = oldest_reg[set_idx];
    assign row       = row_t'(rd_data);

    sacf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS),
        .AW    (SET_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (state_reg == ST_LOOK),
        .waddr (set_idx),
        .wdata (ROW_W'(row_new)),
        .re    (accept),
        .raddr (rd_set),
        .rdata (rd_data)
    );

    // Compare all ways of the row in parallel; at most one valid way matches.
    always_comb
    begin
        hit_found = 1'b0;
        hit_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_found && valid_reg[set_idx][w] && (row[w].ln == ln))
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
        end
    end

    // Read-modify-write of the row, marks and pointer; build the result.
    always_comb
    begin
        row_new     = row;
        valid_next  = valid_reg;
        oldest_next = oldest_reg;
        rsp_next    = '0;

        if (is_access)
        begin
            if (hit_found)
            begin
                rsp_next.hit = 1'b1;
                if (is_store)
                begin
                    row_new[hit_way].dirty = 1'b1;
                end
            end
            else
            begin
                // Evict the oldest way whether or not it holds a line.
                if (valid_reg[set_idx][victim] && row[victim].dirty)
                begin
                    rsp_next.writeback_valid = 1'b1;
                    rsp_next.writeback_addr  = {row[victim].ln, {LINE_SHIFT{1'b0}}};
                end
                row_new[victim].ln         = ln;
                row_new[victim].dirty      = is_store;
                valid_next[set_idx][victim] = 1'b1;
                oldest_next[set_idx] = (victim == WAY_W'(WAYS - 1)) ? '0 : victim + 1'b1;
                rsp_next.fill_valid = 1'b1;
                rsp_next.fill_addr  = {ln, {LINE_SHIFT{1'b0}}};
            end
        end
        else if (is_maint && hit_found)
        begin
            rsp_next.hit = 1'b1;
            // Clean first, then drop the valid mark.
            if (req_reg.clean_flag && row[hit_way].dirty)
            begin
                rsp_next.writeback_valid = 1'b1;
                rsp_next.writeback_addr  = {row[hit_way].ln, {LINE_SHIFT{1'b0}}};
                row_new[hit_way].dirty   = 1'b0;
            end
            if (req_reg.inval_flag)
            begin
                valid_next[set_idx][hit_way] = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            valid_reg  <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == ST_LOOK)
            begin
                valid_reg  <= valid_next;
                oldest_reg <= oldest_next;
            end
        end
    end

    // Payload registers: hold the request, latch the result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (state_reg == ST_LOOK)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

>>> rtl/sacf_chk.sv
// ----------------------------------------------------------------------------
// sacf_chk
// Port-level checks of the cache tag array, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sacf_chk
    import sacf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input logic done,
    input rsp_t rsp
);

    `SACF_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted beat did not raise busy")
    `SACF_ASSERT_NEXT(a_busy_done, busy, !busy && done, "lookup did not finish in one cycle")
    `SACF_ASSERT_IMPLY(a_done_after_busy, done, $past(busy), "result without a lookup")
    `SACF_ASSERT_IMPLY(a_fill_is_miss, done && rsp.fill_valid, !rsp.hit, "fill on a hit")
    `SACF_ASSERT_IMPLY(a_wb_addr_zero, done && !rsp.writeback_valid, rsp.writeback_addr == '0, "stray writeback address")

endmodule

bind set_assoc_cache_fifo_tags sacf_chk u_sacf_chk (.*);

>>> tb/set_assoc_cache_fifo_tags_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_tags_tb
// Self-checking bench for the cache tag array. Sends read, write, maintenance
// and unused-code requests, first directed, then random traffic over a small,
// changing pool of lines. Mirrors the tag state to predict hit, writeback and
// fill for every beat and compares each result strobe against the prediction.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_tags_tb;
    import sacf_pkg::*;

    // Code left unused by the block; it must change nothing and answer zero.
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1528;
    localparam int POOL_LINES   = 12;
    // Slowest run is about 1550 beats plus random idle gaps between them; allow
    // many times that.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_CAP    = 100;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    // Mirror of the tag array: line numbers, marks and FIFO pointers.
    bit [LN_W-1:0] tag_ln    [SETS][WAYS];
    bit            tag_valid [SETS][WAYS];
    bit            tag_dirty [SETS][WAYS];
    int unsigned   fifo_ptr  [SETS];

    rsp_t pending_rsp[$];
    int   error_count = 0;
    int   cycle_count = 0;
    bit   idle_on     = 1'b1;

    set_assoc_cache_fifo_tags DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Bound the run; a hung handshake ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("set_assoc_cache_fifo_tags_tb: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        if (error_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Work out the result of one request and update the mirrored tags.
    function automatic rsp_t predict_lookup(req_t r);
        bit [LN_W-1:0] ln;
        int unsigned   set_i;
        int unsigned   victim;
        int            way_hit;
        rsp_t          o;
        o       = '0;
        ln      = r.addr[ADDR_W-1:LINE_SHIFT];
        set_i   = int'(ln % SETS);
        way_hit = -1;
        for (int w = WAYS - 1; w >= 0; w--)
            if (tag_valid[set_i][w] && tag_ln[set_i][w] == ln)
                way_hit = w;

        if (r.func == FUNC_READ || r.func == FUNC_WRITE)
        begin
            if (way_hit >= 0)
            begin
                o.hit = 1'b1;
                if (r.func == FUNC_WRITE)
                    tag_dirty[set_i][way_hit] = 1'b1;
            end
            else
            begin
                // Replace the oldest way, valid or not; only a valid dirty
                // victim goes back to memory.
                victim = fifo_ptr[set_i] % WAYS;
                if (tag_valid[set_i][victim] && tag_dirty[set_i][victim])
                begin
                    o.writeback_valid = 1'b1;
                    o.writeback_addr  = {tag_ln[set_i][victim], {LINE_SHIFT{1'b0}}};
                end
                tag_ln[set_i][victim]    = ln;
                tag_valid[set_i][victim] = 1'b1;
                tag_dirty[set_i][victim] = (r.func == FUNC_WRITE);
                fifo_ptr[set_i]          = (victim + 1) % WAYS;
                o.fill_valid = 1'b1;
                o.fill_addr  = {ln, {LINE_SHIFT{1'b0}}};
            end
        end
        else if (r.func == FUNC_MAINT && way_hit >= 0)
        begin
            // Clean first, then drop the valid mark; the dirty mark survives
            // an invalidate without clean.
            o.hit = 1'b1;
            if (r.clean_flag && tag_dirty[set_i][way_hit])
            begin
                o.writeback_valid          = 1'b1;
                o.writeback_addr           = {ln, {LINE_SHIFT{1'b0}}};
                tag_dirty[set_i][way_hit]  = 1'b0;
            end
            if (r.inval_flag)
                tag_valid[set_i][way_hit] = 1'b0;
        end
        return o;
    endfunction

    // Send one request beat; optionally idle first. Start stays high on return
    // so back-to-back beats never drop it within one step.
    task automatic send_req(logic [1:0] func, logic [ADDR_W-1:0] addr,
                            logic clean, logic inval);
        req_t r;
        bit   taken;
        r.func       = func;
        r.addr       = addr;
        r.clean_flag = clean;
        r.inval_flag = inval;
        if (idle_on && $urandom_range(0, 99) < 20)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        // Sample busy mid-cycle; a low busy means the coming edge takes the beat.
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        pending_rsp.insert(pending_rsp.size(), predict_lookup(r));
    endtask

    // Check each result strobe against the oldest prediction.
    always @(negedge clk)
    begin
        rsp_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = pending_rsp[0];
                pending_rsp.delete(0);
                if (rsp.hit !== want.hit)
                    report_mismatch($sformatf("hit %b, want %b", rsp.hit, want.hit));
                if (rsp.writeback_valid !== want.writeback_valid)
                    report_mismatch($sformatf("writeback_valid %b, want %b",
                                              rsp.writeback_valid, want.writeback_valid));
                if (rsp.writeback_addr !== want.writeback_addr)
                    report_mismatch($sformatf("writeback_addr %h, want %h",
                                              rsp.writeback_addr, want.writeback_addr));
                if (rsp.fill_valid !== want.fill_valid)
                    report_mismatch($sformatf("fill_valid %b, want %b",
                                              rsp.fill_valid, want.fill_valid));
                if (rsp.fill_addr !== want.fill_addr)
                    report_mismatch($sformatf("fill_addr %h, want %h",
                                              rsp.fill_addr, want.fill_addr));
            end
        end
    end

    // Address extremes, write hits and ignored flags on accesses.
    task automatic test_access_extremes();
        send_req(FUNC_READ,  64'h0, 1'b0, 1'b0);
        send_req(FUNC_WRITE, 64'h1F, 1'b1, 1'b1);
        send_req(FUNC_READ,  '1, 1'b0, 1'b0);
        send_req(FUNC_WRITE, '1, 1'b0, 1'b1);
        send_req(FUNC_READ,  64'h4, 1'b1, 1'b1);
    endtask

    // Fill set 0, then evict the dirty oldest way and a clean one.
    task automatic test_fifo_eviction();
        send_req(FUNC_READ,  64'h100, 1'b0, 1'b0);
        send_req(FUNC_READ,  64'h200, 1'b0, 1'b0);
        send_req(FUNC_READ,  64'h300, 1'b0, 1'b0);
        send_req(FUNC_WRITE, 64'h400, 1'b0, 1'b0);
        send_req(FUNC_READ,  64'h500, 1'b0, 1'b0);
    endtask

    // Clean, invalidate, both, and a maintenance miss.
    task automatic test_maintenance();
        send_req(FUNC_MAINT, 64'h400, 1'b1, 1'b0);
        send_req(FUNC_MAINT, 64'h41C, 1'b1, 1'b0);
        send_req(FUNC_WRITE, 64'h400, 1'b0, 1'b0);
        send_req(FUNC_MAINT, 64'h400, 1'b0, 1'b1);
        send_req(FUNC_READ,  64'h400, 1'b0, 1'b0);
        send_req(FUNC_WRITE, 64'h400, 1'b0, 1'b0);
        send_req(FUNC_MAINT, 64'h400, 1'b1, 1'b1);
        send_req(FUNC_MAINT, 64'hDEAD_BEEF_0000_0000, 1'b1, 1'b1);
    endtask

    // Unused code and a flagless maintenance hit.
    task automatic test_unused_func();
        send_req(FUNC_NONE,  '1, 1'b1, 1'b1);
        send_req(FUNC_NONE,  64'h0, 1'b0, 1'b0);
        send_req(FUNC_MAINT, '1, 1'b0, 1'b0);
    endtask

    // Random traffic over a small pool of lines crowded into a few sets, so
    // hits, evictions and maintenance hits stay frequent; refresh the pool
    // now and then so every address bit toggles.
    task automatic test_random_traffic();
        bit [LN_W-1:0]     pool [POOL_LINES];
        bit [SET_W-1:0]    hot  [3];
        logic [ADDR_W-1:0] addr;
        logic [1:0]        func;
        int unsigned       pick;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Hold idling off for one long stretch.
            idle_on = !(n >= 500 && n < 800);
            if (n % 200 == 0)
            begin
                foreach (hot[h])
                    hot[h] = SET_W'($urandom);
                foreach (pool[p])
                begin
                    pool[p] = LN_W'({$urandom, $urandom});
                    if ($urandom_range(0, 3) != 0)
                        pool[p][SET_W-1:0] = hot[$urandom_range(0, 2)];
                end
            end
            if ($urandom_range(0, 9) == 0)
                addr = {$urandom, $urandom};
            else
                addr = {pool[$urandom_range(0, POOL_LINES - 1)],
                        LINE_SHIFT'($urandom)};
            pick = $urandom_range(0, 99);
            if (pick < 40)
                func = FUNC_READ;
            else if (pick < 75)
                func = FUNC_WRITE;
            else if (pick < 96)
                func = FUNC_MAINT;
            else
                func = FUNC_NONE;
            send_req(func, addr, 1'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        for (int s = 0; s < SETS; s++)
        begin
            fifo_ptr[s] = 0;
            for (int w = 0; w < WAYS; w++)
            begin
                tag_ln[s][w]    = '0;
                tag_valid[s][w] = 1'b0;
                tag_dirty[s][w] = 1'b0;
            end
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_access_extremes();
        test_fifo_eviction();
        test_maintenance();
        test_unused_func();
        test_random_traffic();

        // Drop start, drain outstanding results, then let the pipe settle.
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("set_assoc_cache_fifo_tags_tb: done, clean");
        else
            $display("set_assoc_cache_fifo_tags_tb: done, errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/sacf_pkg.sv
rtl/sacf_ram.sv
rtl/set_assoc_cache_fifo_tags.sv
rtl/sacf_chk.sv
tb/set_assoc_cache_fifo_tags_tb.sv
